### rtl/sha256_pkg.sv
// Shared types, constants and helper functions for the SHA-256 digest block.
package sha256_pkg;

    // Eight 32-bit words, element 0 first (chain value a..h order)
    typedef logic [0:7][31:0] t_words8;

    // Sixteen-word message window, element 15 holds the oldest word
    typedef logic [15:0][31:0] t_win;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PAD,
        ST_ROUND,
        ST_FOLD,
        ST_OUT
    } t_state;

    localparam logic [7:0] PAD_MARK = 8'h80;
    localparam logic [5:0] LEN_POS  = 6'd56;
    localparam logic [5:0] LAST_POS = 6'd63;
    localparam logic [5:0] LAST_RND = 6'd63;
    localparam logic [2:0] LAST_IDX = 3'd7;

    localparam t_words8 H_INIT = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    // Rotate right by a fixed amount
    function automatic logic [31:0] ror(input logic [31:0] v, input int unsigned s);
        return (v >> s) | (v << (32 - s));
    endfunction

    // Round constant lookup
    function automatic logic [31:0] round_k(input logic [5:0] i);
        logic [31:0] k;
        unique case (i)
            6'd0:  k = 32'h428a2f98;  6'd1:  k = 32'h71374491;
            6'd2:  k = 32'hb5c0fbcf;  6'd3:  k = 32'he9b5dba5;
            6'd4:  k = 32'h3956c25b;  6'd5:  k = 32'h59f111f1;
            6'd6:  k = 32'h923f82a4;  6'd7:  k = 32'hab1c5ed5;
            6'd8:  k = 32'hd807aa98;  6'd9:  k = 32'h12835b01;
            6'd10: k = 32'h243185be;  6'd11: k = 32'h550c7dc3;
            6'd12: k = 32'h72be5d74;  6'd13: k = 32'h80deb1fe;
            6'd14: k = 32'h9bdc06a7;  6'd15: k = 32'hc19bf174;
            6'd16: k = 32'he49b69c1;  6'd17: k = 32'hefbe4786;
            6'd18: k = 32'h0fc19dc6;  6'd19: k = 32'h240ca1cc;
            6'd20: k = 32'h2de92c6f;  6'd21: k = 32'h4a7484aa;
            6'd22: k = 32'h5cb0a9dc;  6'd23: k = 32'h76f988da;
            6'd24: k = 32'h983e5152;  6'd25: k = 32'ha831c66d;
            6'd26: k = 32'hb00327c8;  6'd27: k = 32'hbf597fc7;
            6'd28: k = 32'hc6e00bf3;  6'd29: k = 32'hd5a79147;
            6'd30: k = 32'h06ca6351;  6'd31: k = 32'h14292967;
            6'd32: k = 32'h27b70a85;  6'd33: k = 32'h2e1b2138;
            6'd34: k = 32'h4d2c6dfc;  6'd35: k = 32'h53380d13;
            6'd36: k = 32'h650a7354;  6'd37: k = 32'h766a0abb;
            6'd38: k = 32'h81c2c92e;  6'd39: k = 32'h92722c85;
            6'd40: k = 32'ha2bfe8a1;  6'd41: k = 32'ha81a664b;
            6'd42: k = 32'hc24b8b70;  6'd43: k = 32'hc76c51a3;
            6'd44: k = 32'hd192e819;  6'd45: k = 32'hd6990624;
            6'd46: k = 32'hf40e3585;  6'd47: k = 32'h106aa070;
            6'd48: k = 32'h19a4c116;  6'd49: k = 32'h1e376c08;
            6'd50: k = 32'h2748774c;  6'd51: k = 32'h34b0bcb5;
            6'd52: k = 32'h391c0cb3;  6'd53: k = 32'h4ed8aa4a;
            6'd54: k = 32'h5b9cca4f;  6'd55: k = 32'h682e6ff3;
            6'd56: k = 32'h748f82ee;  6'd57: k = 32'h78a5636f;
            6'd58: k = 32'h84c87814;  6'd59: k = 32'h8cc70208;
            6'd60: k = 32'h90befffa;  6'd61: k = 32'ha4506ceb;
            6'd62: k = 32'hbef9a3f7;  6'd63: k = 32'hc67178f2;
            default: k = 32'h0;
        endcase
        return k;
    endfunction

endpackage

### rtl/sha256_round.sv
// One SHA-256 round plus one message schedule expansion step.
module sha256_round (
    input  sha256_pkg::t_words8 i_vars,  // working variables a..h
    input  sha256_pkg::t_win    i_win,   // schedule window, oldest word at 15
    input  logic [31:0]         i_k,     // round constant
    output sha256_pkg::t_words8 o_vars,  // working variables after the round
    output logic [31:0]         o_wnew   // schedule word sixteen rounds ahead
);

    logic [31:0] wt, w1, w9, w14;
    logic [31:0] sig0, sig1, ssum0, ssum1, ch, maj, t1, t2;

    // Tap the window at the schedule offsets
    assign wt  = i_win[15];
    assign w1  = i_win[14];
    assign w9  = i_win[6];
    assign w14 = i_win[1];

    // Expand the next schedule word
    assign sig0 = sha256_pkg::ror(w1, 7) ^ sha256_pkg::ror(w1, 18) ^ (w1 >> 3);
    assign sig1 = sha256_pkg::ror(w14, 17) ^ sha256_pkg::ror(w14, 19) ^ (w14 >> 10);
    assign o_wnew = wt + sig0 + w9 + sig1;

    // Compression round
    assign ssum1 = sha256_pkg::ror(i_vars[4], 6) ^ sha256_pkg::ror(i_vars[4], 11)
                 ^ sha256_pkg::ror(i_vars[4], 25);
    assign ch    = (i_vars[4] & i_vars[5]) ^ (~i_vars[4] & i_vars[6]);
    assign ssum0 = sha256_pkg::ror(i_vars[0], 2) ^ sha256_pkg::ror(i_vars[0], 13)
                 ^ sha256_pkg::ror(i_vars[0], 22);
    assign maj   = (i_vars[0] & i_vars[1]) ^ (i_vars[0] & i_vars[2])
                 ^ (i_vars[1] & i_vars[2]);
    assign t1    = i_vars[7] + ssum1 + ch + i_k + wt;
    assign t2    = ssum0 + maj;

    // Rotate the working variables
    always_comb begin
        o_vars[7] = i_vars[6];
        o_vars[6] = i_vars[5];
        o_vars[5] = i_vars[4];
        o_vars[4] = i_vars[3] + t1;
        o_vars[3] = i_vars[2];
        o_vars[2] = i_vars[1];
        o_vars[1] = i_vars[0];
        o_vars[0] = t1 + t2;
    end

endmodule

### rtl/sha256_message_digest.sv
// Top level of the SHA-256 digest block: byte intake, padding, round sequencer, output.
//
// Message bytes are taken one per cycle and shifted into a 64-byte window; the
// 64th byte of a block starts compression, which holds tready low through the
// 64 rounds in the single shared round unit and the fold of the working
// variables into the chain value. An end-of-message transfer starts padding,
// which writes one pad byte per cycle up to the end of the block (two blocks
// when 56 or more bytes are pending), compresses each padded block, then
// presents the eight digest words, most significant first, one per output
// transfer; the block then takes a new message. The end-of-message latency is
// set by the padding sequence, the compression of each padded block and the
// output transfers.
module sha256_message_digest (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] message_byte
    input  logic        s_axis_tuser,   // [0] kind: 0 = byte, 1 = end of message
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // [31:0] digest_word
    output logic [2:0]  m_axis_tuser,   // [2:0] word_index
    output logic        m_axis_tlast    // last digest word
);

    sha256_pkg::t_state  r_state, n_state;
    sha256_pkg::t_words8 r_chain, r_vars, round_vars;
    sha256_pkg::t_win    r_win;
    logic [60:0]         r_count;
    logic [5:0]          r_pos;
    logic [5:0]          r_rnd;
    logic [2:0]          r_idx;
    logic                r_pad;
    logic                r_first;
    logic                r_two;
    logic                r_final;
    logic [31:0]         wnew;
    logic [63:0]         bit_len;
    logic [7:0]          pad_byte;
    logic                in_xfer, out_xfer;

    assign in_xfer  = s_axis_tvalid && s_axis_tready;
    assign out_xfer = m_axis_tvalid && m_axis_tready;

    // Shared round unit
    sha256_round u_round (
        .i_vars (r_vars),
        .i_win  (r_win),
        .i_k    (sha256_pkg::round_k(r_rnd)),
        .o_vars (round_vars),
        .o_wnew (wnew)
    );

    // Select the next pad byte: marker, zero fill or big-endian bit length
    assign bit_len = {r_count, 3'b000};
    always_comb begin
        if (r_first) begin
            pad_byte = sha256_pkg::PAD_MARK;
        end else if (r_pos >= sha256_pkg::LEN_POS && !r_two) begin
            pad_byte = bit_len[{~r_pos[2:0], 3'b000} +: 8];
        end else begin
            pad_byte = 8'h00;
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            sha256_pkg::ST_IDLE: begin
                if (in_xfer) begin
                    if (s_axis_tuser) begin
                        n_state = sha256_pkg::ST_PAD;
                    end else if (r_pos == sha256_pkg::LAST_POS) begin
                        n_state = sha256_pkg::ST_ROUND;
                    end
                end
            end
            sha256_pkg::ST_PAD: begin
                if (r_pos == sha256_pkg::LAST_POS) begin
                    n_state = sha256_pkg::ST_ROUND;
                end
            end
            sha256_pkg::ST_ROUND: begin
                if (r_rnd == sha256_pkg::LAST_RND) begin
                    n_state = sha256_pkg::ST_FOLD;
                end
            end
            sha256_pkg::ST_FOLD: begin
                priority if (r_final) begin
                    n_state = sha256_pkg::ST_OUT;
                end else if (r_pad) begin
                    n_state = sha256_pkg::ST_PAD;
                end else begin
                    n_state = sha256_pkg::ST_IDLE;
                end
            end
            sha256_pkg::ST_OUT: begin
                if (out_xfer && r_idx == sha256_pkg::LAST_IDX) begin
                    n_state = sha256_pkg::ST_IDLE;
                end
            end
            default: n_state = sha256_pkg::ST_IDLE;
        endcase
    end

    // Handshake outputs
    always_comb begin
        s_axis_tready = (r_state == sha256_pkg::ST_IDLE);
        m_axis_tvalid = (r_state == sha256_pkg::ST_OUT);
    end

    assign m_axis_tdata = r_chain[r_idx];
    assign m_axis_tuser = r_idx;
    assign m_axis_tlast = (r_idx == sha256_pkg::LAST_IDX);

    // Hold state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= sha256_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Control registers and chain value
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_chain <= sha256_pkg::H_INIT;
            r_count <= '0;
            r_pos   <= '0;
            r_rnd   <= '0;
            r_idx   <= '0;
            r_pad   <= 1'b0;
            r_first <= 1'b0;
            r_two   <= 1'b0;
            r_final <= 1'b0;
        end else begin
            unique case (r_state)
                sha256_pkg::ST_IDLE: begin
                    r_rnd <= '0;
                    if (in_xfer) begin
                        if (s_axis_tuser) begin
                            r_pad   <= 1'b1;
                            r_first <= 1'b1;
                            r_two   <= (r_pos >= sha256_pkg::LEN_POS);
                        end else begin
                            r_count <= r_count + 61'd1;
                            r_pos   <= r_pos + 6'd1;
                            r_final <= 1'b0;
                        end
                    end
                end
                sha256_pkg::ST_PAD: begin
                    r_rnd   <= '0;
                    r_first <= 1'b0;
                    r_pos   <= r_pos + 6'd1;
                    if (r_pos == sha256_pkg::LAST_POS) begin
                        r_final <= !r_two;
                        r_two   <= 1'b0;
                    end
                end
                sha256_pkg::ST_ROUND: begin
                    r_rnd <= r_rnd + 6'd1;
                end
                sha256_pkg::ST_FOLD: begin
                    for (int i = 0; i < 8; i++) begin
                        r_chain[i] <= r_chain[i] + r_vars[i];
                    end
                    r_idx <= '0;
                end
                sha256_pkg::ST_OUT: begin
                    if (out_xfer) begin
                        r_idx <= r_idx + 3'd1;
                        if (r_idx == sha256_pkg::LAST_IDX) begin
                            r_chain <= sha256_pkg::H_INIT;
                            r_count <= '0;
                            r_pad   <= 1'b0;
                            r_final <= 1'b0;
                        end
                    end
                end
                default: r_rnd <= '0;
            endcase
        end
    end

    // Window and working variables: shift bytes in, then advance one round a cycle
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            sha256_pkg::ST_IDLE: begin
                r_vars <= r_chain;
                if (in_xfer && !s_axis_tuser) begin
                    r_win <= {r_win[15][23:0], r_win[14:0], s_axis_tdata};
                end
            end
            sha256_pkg::ST_PAD: begin
                r_vars <= r_chain;
                r_win  <= {r_win[15][23:0], r_win[14:0], pad_byte};
            end
            sha256_pkg::ST_ROUND: begin
                r_vars <= round_vars;
                r_win  <= {r_win[14:0], wnew};
            end
            sha256_pkg::ST_FOLD: begin
                r_vars <= r_vars;
            end
            sha256_pkg::ST_OUT: begin
                r_vars <= r_chain;
            end
            default: r_vars <= r_chain;
        endcase
    end

endmodule

### dv/testbench.sv
// Self-checking testbench for the SHA-256 message digest block.
`timescale 1ns / 1ps

module testbench;

    localparam logic KIND_BYTE = 1'b0;
    localparam logic KIND_END  = 1'b1;

    localparam int PAD_SPILL     = 56;    // pending bytes that push the length into a second block
    localparam int STALL_LIMIT   = 5000;  // cycles without any transfer before giving up
    localparam int TAIL_CYCLES   = 400;   // settle time after the last digest word
    localparam int RANDOM_ITEMS  = 40;
    localparam int RANDOM_MSGS   = 3;

    localparam logic [0:7][31:0] IV_WORDS = {
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [0:63][31:0] ROUND_CONST = {
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    typedef struct packed {
        logic [31:0] word;
        logic [2:0]  index;
        logic        tail;
    } t_digest_beat;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = 8'h00;   // [7:0] message_byte
    logic        s_axis_tuser = 1'b0;    // [0] kind
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;           // [31:0] digest_word
    logic [2:0]  m_axis_tuser;           // [2:0] word_index
    logic        m_axis_tlast;

    // Digest model state
    logic [31:0] hash_words [8];
    logic [7:0]  block_bytes [64];
    logic [60:0] msg_len;

    t_digest_beat digest_q [$];
    int          err_count = 0;
    int          items_sent = 0;
    int          stall_cycles = 0;
    int          ready_hold = 0;
    bit          quiet = 1'b0;

    sha256_message_digest u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Rotate a word right
    function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
        logic [63:0] both;
        both = {x, x} >> n;
        return both[31:0];
    endfunction

    // Run the 64 rounds over the current block and fold into the hash words
    function automatic void mix_block();
        logic [31:0] w [16];
        logic [31:0] a, b, c, d, e, f, g, h;
        logic [31:0] t1, t2, sg0, sg1;
        int i;
        int r;
        for (i = 0; i < 16; i++) begin
            w[i] = {block_bytes[4*i], block_bytes[4*i+1], block_bytes[4*i+2],
                    block_bytes[4*i+3]};
        end
        a = hash_words[0]; b = hash_words[1]; c = hash_words[2]; d = hash_words[3];
        e = hash_words[4]; f = hash_words[5]; g = hash_words[6]; h = hash_words[7];
        for (r = 0; r < 64; r++) begin
            // extend the schedule in place once the block words are used up
            if (r >= 16) begin
                sg0 = rotr(w[(r-15)&15], 7) ^ rotr(w[(r-15)&15], 18) ^ (w[(r-15)&15] >> 3);
                sg1 = rotr(w[(r-2)&15], 17) ^ rotr(w[(r-2)&15], 19) ^ (w[(r-2)&15] >> 10);
                w[r&15] = w[r&15] + sg0 + w[(r-7)&15] + sg1;
            end
            t1 = h + (rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25)) + ((e & f) ^ (~e & g))
               + ROUND_CONST[r] + w[r&15];
            t2 = (rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
            h = g; g = f; f = e; e = d + t1;
            d = c; c = b; b = a; a = t1 + t2;
        end
        hash_words[0] += a; hash_words[1] += b; hash_words[2] += c; hash_words[3] += d;
        hash_words[4] += e; hash_words[5] += f; hash_words[6] += g; hash_words[7] += h;
    endfunction

    function automatic void restart_digest();
        int i;
        for (i = 0; i < 8; i++) hash_words[i] = IV_WORDS[i];
        msg_len = '0;
    endfunction

    // Update the digest model with one accepted item; queue digest words on end
    function automatic void absorb_item(input logic kind, input logic [7:0] data);
        logic [63:0] bit_len;
        t_digest_beat beat;
        int pos;
        int i;
        pos = int'(msg_len[5:0]);
        if (kind == KIND_BYTE) begin
            block_bytes[pos] = data;
            msg_len = msg_len + 61'd1;
            if (pos == 63) mix_block();
        end else begin
            block_bytes[pos] = 8'h80;
            for (i = pos + 1; i < 64; i++) block_bytes[i] = 8'h00;
            // length field does not fit: flush this block and pad a fresh one
            if (pos >= PAD_SPILL) begin
                mix_block();
                for (i = 0; i < 64; i++) block_bytes[i] = 8'h00;
            end
            bit_len = {msg_len, 3'b000};
            for (i = 0; i < 8; i++) block_bytes[63-i] = bit_len[8*i +: 8];
            mix_block();
            for (i = 0; i < 8; i++) begin
                beat.word  = hash_words[i];
                beat.index = 3'(i);
                beat.tail  = (i == 7);
                digest_q.push_back(beat);
            end
            restart_digest();
        end
    endfunction

    // Mostly back-to-back, sometimes a short pause, rarely a long one
    function automatic int draw_gap();
        int r;
        r = $urandom_range(0, 99);
        if (quiet) return 0;
        if (r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    // Present one item and hold it until the transfer happens
    task automatic send_item(input logic kind, input logic [7:0] data);
        int gap;
        gap = draw_gap();
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= data;
        s_axis_tuser  <= kind;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        absorb_item(kind, data);
        items_sent++;
    endtask

    task automatic send_message(input int len);
        int i;
        for (i = 0; i < len; i++) send_item(KIND_BYTE, 8'($urandom));
        send_item(KIND_END, 8'($urandom));
    endtask

    // Hold off the sender until every queued digest word has come out
    task automatic drain_digests();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (digest_q.size() != 0) @(posedge i_clk);
    endtask

    // Empty message, "abc", single extreme bytes, back-to-back ends
    task automatic test_short_messages();
        send_item(KIND_END, 8'hff);
        send_item(KIND_BYTE, 8'h61);
        send_item(KIND_BYTE, 8'h62);
        send_item(KIND_BYTE, 8'h63);
        send_item(KIND_END, 8'h00);
        send_item(KIND_BYTE, 8'h00);
        send_item(KIND_END, 8'h5a);
        send_item(KIND_BYTE, 8'hff);
        send_item(KIND_END, 8'ha5);
        send_item(KIND_END, 8'h00);
        send_item(KIND_END, 8'hff);
    endtask

    // Lengths on either side of the point where padding spills into a second block
    task automatic test_pad_boundaries();
        send_message(55);
        send_message(56);
    endtask

    // Random message lengths with random content and idling
    task automatic test_random_stream();
        int start_items;
        int msgs;
        int r;
        int len;
        start_items = items_sent;
        msgs = 0;
        while (items_sent - start_items < RANDOM_ITEMS || msgs < RANDOM_MSGS) begin
            r = $urandom_range(0, 99);
            if (r < 70) len = $urandom_range(0, 12);
            else if (r < 90) len = $urandom_range(13, 40);
            else len = $urandom_range(60, 70);
            quiet = ($urandom_range(0, 4) == 0);
            send_message(len);
            msgs++;
        end
        quiet = 1'b0;
    endtask

    // Output side: random stalls, mostly short, a few long
    always @(posedge i_clk) begin
        if (quiet) begin
            m_axis_tready <= 1'b1;
            ready_hold <= 0;
        end else if (ready_hold > 0) begin
            m_axis_tready <= 1'b0;
            ready_hold <= ready_hold - 1;
        end else if ($urandom_range(0, 99) < 70) begin
            m_axis_tready <= 1'b1;
        end else begin
            m_axis_tready <= 1'b0;
            ready_hold <= draw_gap();
        end
    end

    // Compare each digest word transfer against the oldest expectation
    always @(posedge i_clk) begin
        t_digest_beat want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (digest_q.size() == 0) begin
                $display("%0t: unexpected digest word %h index %0d last %b",
                         $time, m_axis_tdata, m_axis_tuser, m_axis_tlast);
                err_count++;
            end else begin
                want = digest_q.pop_front();
                if (m_axis_tdata !== want.word) begin
                    $display("%0t: digest word mismatch: expected %h actual %h",
                             $time, want.word, m_axis_tdata);
                    err_count++;
                end
                if (m_axis_tuser !== want.index) begin
                    $display("%0t: word index mismatch: expected %0d actual %0d",
                             $time, want.index, m_axis_tuser);
                    err_count++;
                end
                if (m_axis_tlast !== want.tail) begin
                    $display("%0t: last flag mismatch: expected %b actual %b",
                             $time, want.tail, m_axis_tlast);
                    err_count++;
                end
            end
        end
    end

    // Stop the run when neither side has moved for too long
    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("%0t: no transfer for %0d cycles", $time, STALL_LIMIT);
            $display("testbench: errors");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial begin
        restart_digest();
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_short_messages();
        drain_digests();
        test_pad_boundaries();
        test_random_stream();

        drain_digests();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (digest_q.size() != 0) begin
            $display("%0t: %0d digest words never arrived", $time, digest_q.size());
            err_count++;
        end
        if (err_count == 0) begin
            $display("testbench: clean");
        end else begin
            $display("testbench: errors");
        end
        $finish;
    end

endmodule

### sha256_message_digest.f
rtl/sha256_pkg.sv
rtl/sha256_round.sv
rtl/sha256_message_digest.sv
dv/testbench.sv
